// File: rtl/core/csfp_pkg.sv
// Shared types and constants for the color swatch file parser.
// Holds the parse phase codes, the result status codes and the result struct.
package csfp_pkg;

  localparam int unsigned PhaseW = 4;

  // Parse phase: which file word the parser expects next.
  localparam logic [PhaseW-1:0] PH_VERSION = 4'd0;
  localparam logic [PhaseW-1:0] PH_COUNT   = 4'd1;
  localparam logic [PhaseW-1:0] PH_SPACE   = 4'd2;
  localparam logic [PhaseW-1:0] PH_COMP1   = 4'd3;
  localparam logic [PhaseW-1:0] PH_COMP2   = 4'd4;
  localparam logic [PhaseW-1:0] PH_COMP3   = 4'd5;
  localparam logic [PhaseW-1:0] PH_COMP4   = 4'd6;
  localparam logic [PhaseW-1:0] PH_ZERO    = 4'd7;
  localparam logic [PhaseW-1:0] PH_NAMELEN = 4'd8;
  localparam logic [PhaseW-1:0] PH_NAME    = 4'd9;
  localparam logic [PhaseW-1:0] PH_DONE    = 4'd10;

  localparam logic [1:0] ST_RGB         = 2'd0;
  localparam logic [1:0] ST_SKIPPED     = 2'd1;
  localparam logic [1:0] ST_BAD_VERSION = 2'd2;
  localparam logic [1:0] ST_TRUNCATED   = 2'd3;

  localparam logic [15:0] VERSION_ONE = 16'd1;
  localparam logic [15:0] VERSION_TWO = 16'd2;

  typedef struct packed {
    logic        valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] entry_index;
    logic [1:0]  status;
    logic        last_entry;
  } csfp_result_t;

endpackage

// File: rtl/core/csfp_parse.sv
// Parser state and per-word step logic for the color swatch file parser.
// Depends on csfp_pkg for phase codes, status codes and the result struct.
module csfp_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [15:0]           word,
  input  logic                  file_end,
  output csfp_pkg::csfp_result_t res
);

  logic [csfp_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic        version_two_r, version_two_nxt;
  logic [15:0] entries_total_r, entries_total_nxt;
  logic [15:0] entries_done_r, entries_done_nxt;
  logic [15:0] words_left_r, words_left_nxt;
  logic        entry_is_rgb_r, entry_is_rgb_nxt;
  logic [7:0]  red_held_r, red_held_nxt;
  logic [7:0]  green_held_r, green_held_nxt;
  logic [7:0]  blue_held_r, blue_held_nxt;

  logic        is_last;
  logic        finish;
  logic [15:0] words_dec;
  logic [7:0]  hi;

  assign hi        = word[15:8];
  assign is_last   = (entries_done_r + 16'd1) == entries_total_r;
  assign words_dec = words_left_r - 16'd1;

  always_comb begin
    phase_nxt         = phase_r;
    version_two_nxt   = version_two_r;
    entries_total_nxt = entries_total_r;
    entries_done_nxt  = entries_done_r;
    words_left_nxt    = words_left_r;
    entry_is_rgb_nxt  = entry_is_rgb_r;
    red_held_nxt      = red_held_r;
    green_held_nxt    = green_held_r;
    blue_held_nxt     = blue_held_r;
    finish            = 1'b0;
    res               = '0;

    if (phase_r < csfp_pkg::PH_DONE) begin
      if (file_end) begin
        phase_nxt = csfp_pkg::PH_DONE;
        res.valid = 1'b1;
        if (phase_r == csfp_pkg::PH_VERSION) begin
          res.status = csfp_pkg::ST_BAD_VERSION;
        end else begin
          res.status      = csfp_pkg::ST_TRUNCATED;
          res.entry_index = entries_done_r;
        end
      end else begin
        unique case (phase_r)
          csfp_pkg::PH_VERSION: begin
            if (word != csfp_pkg::VERSION_ONE && word != csfp_pkg::VERSION_TWO) begin
              phase_nxt  = csfp_pkg::PH_DONE;
              res.valid  = 1'b1;
              res.status = csfp_pkg::ST_BAD_VERSION;
            end else begin
              version_two_nxt = (word == csfp_pkg::VERSION_TWO);
              phase_nxt       = csfp_pkg::PH_COUNT;
            end
          end
          csfp_pkg::PH_COUNT: begin
            entries_total_nxt = word;
            entries_done_nxt  = '0;
            phase_nxt = (word == 16'd0) ? csfp_pkg::PH_DONE : csfp_pkg::PH_SPACE;
          end
          csfp_pkg::PH_SPACE: begin
            entry_is_rgb_nxt = (word == 16'd0);
            red_held_nxt     = '0;
            green_held_nxt   = '0;
            blue_held_nxt    = '0;
            phase_nxt        = csfp_pkg::PH_COMP1;
          end
          csfp_pkg::PH_COMP1: begin
            if (entry_is_rgb_r) red_held_nxt = hi;
            phase_nxt = csfp_pkg::PH_COMP2;
          end
          csfp_pkg::PH_COMP2: begin
            if (entry_is_rgb_r) green_held_nxt = hi;
            phase_nxt = csfp_pkg::PH_COMP3;
          end
          csfp_pkg::PH_COMP3: begin
            if (entry_is_rgb_r) blue_held_nxt = hi;
            phase_nxt = csfp_pkg::PH_COMP4;
          end
          csfp_pkg::PH_COMP4: begin
            if (!version_two_r) begin
              finish = 1'b1;
            end else begin
              phase_nxt = csfp_pkg::PH_ZERO;
            end
          end
          csfp_pkg::PH_ZERO: begin
            phase_nxt = csfp_pkg::PH_NAMELEN;
          end
          csfp_pkg::PH_NAMELEN: begin
            if (word == 16'd0) begin
              finish = 1'b1;
            end else begin
              words_left_nxt = word;
              phase_nxt      = csfp_pkg::PH_NAME;
            end
          end
          default: begin
            words_left_nxt = words_dec;
            if (words_dec == 16'd0) finish = 1'b1;
          end
        endcase
      end
    end

    // Closing an entry reports its color (or skipped status) and moves on.
    if (finish) begin
      res.valid       = 1'b1;
      res.entry_index = entries_done_r;
      res.last_entry  = is_last;
      if (entry_is_rgb_r) begin
        res.status = csfp_pkg::ST_RGB;
        res.red    = red_held_r;
        res.green  = green_held_r;
        res.blue   = blue_held_r;
      end else begin
        res.status = csfp_pkg::ST_SKIPPED;
      end
      entries_done_nxt = entries_done_r + 16'd1;
      phase_nxt = is_last ? csfp_pkg::PH_DONE : csfp_pkg::PH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= csfp_pkg::PH_VERSION;
      version_two_r   <= 1'b0;
      entries_total_r <= '0;
      entries_done_r  <= '0;
      words_left_r    <= '0;
      entry_is_rgb_r  <= 1'b0;
      red_held_r      <= '0;
      green_held_r    <= '0;
      blue_held_r     <= '0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      version_two_r   <= version_two_nxt;
      entries_total_r <= entries_total_nxt;
      entries_done_r  <= entries_done_nxt;
      words_left_r    <= words_left_nxt;
      entry_is_rgb_r  <= entry_is_rgb_nxt;
      red_held_r      <= red_held_nxt;
      green_held_r    <= green_held_nxt;
      blue_held_r     <= blue_held_nxt;
    end
  end

endmodule

// File: rtl/core/color_swatch_file_parser.sv
// Top level of the color swatch file parser: input register, parser, result register.
// Depends on csfp_pkg and csfp_parse.
//
//   Channel  Direction  Payload
//   in_      slave      tdata = file word, tlast = end of file (no word carried)
//   out_     master     tdata = red, green, blue, entry index; tuser = status;
//                       tlast = final announced entry
//
// One file word per cycle when the result side keeps up; a word is held in the input
// register and its result, if any, is then captured in the output register. The parser
// step handles one word a cycle while it is not held by a stalled result.
// Synchronous active-low reset returns the parser to expecting the version word.
// A stalled result holds the parser and input register; in_tready drops only then.
module color_swatch_file_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] word
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue, [39:24] entry_index
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  logic        in_valid_r;
  logic [15:0] in_word_r;
  logic        in_end_r;
  logic        advance;

  csfp_pkg::csfp_result_t res;

  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [1:0]  out_status_r;
  logic        out_last_r;

  // The held word moves into the parser once the result register is free.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_word_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  csfp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .word     (in_word_r),
    .file_end (in_end_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_data_r   <= {res.entry_index, res.blue, res.green, res.red};
      out_status_r <= res.status;
      out_last_r   <= res.last_entry;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for color_swatch_file_parser: one palette file streamed in,
// every result checked against a cycle-free predictor of the parser. Depends on csfp_pkg.
// Random gaps on both stream sides and one long result-side stall exercise back-pressure.
module tb_top;

  localparam int BodyWords  = 1100;
  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;
  localparam int DrainWait  = 10;

  typedef struct packed {
    logic [15:0] word;
    logic        fend;
  } file_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] entry_index;
    logic [1:0]  status;
    logic        last_entry;
  } swatch_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  color_swatch_file_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Parser state as the predictor tracks it.
  logic [csfp_pkg::PhaseW-1:0] ph = csfp_pkg::PH_VERSION;
  bit          is_v2 = 1'b0;
  logic [15:0] n_total = '0;
  logic [15:0] n_done = '0;
  logic [15:0] name_left = '0;
  bit          is_rgb = 1'b0;
  logic [7:0]  red_q = '0;
  logic [7:0]  green_q = '0;
  logic [7:0]  blue_q = '0;

  file_word_t file_words[$];
  file_word_t body_words[$];
  swatch_t    pending_swatches[$];

  bit          in_fire = 1'b0;
  int          in_pause = 0;
  bit          in_steady = 1'b0;
  int          out_pause = 0;
  bit          out_steady = 1'b0;
  bit          long_hold_done = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          rgb_seen = 0;
  int          skipped_seen = 0;
  int          errors_seen = 0;
  int          cycle_cnt = 0;
  int          words_sent = 0;
  int          entries_full = 0;
  logic [15:0] file_version;
  logic [15:0] file_count;
  bit          file_cut;

  function automatic bit close_entry(output swatch_t res);
    bit fin;
    fin = 16'(n_done + 16'd1) == n_total;
    res = '0;
    if (is_rgb) begin
      res.red = red_q;
      res.green = green_q;
      res.blue = blue_q;
      res.status = csfp_pkg::ST_RGB;
    end else begin
      res.status = csfp_pkg::ST_SKIPPED;
    end
    res.entry_index = n_done;
    res.last_entry = fin;
    n_done = 16'(n_done + 16'd1);
    ph = fin ? csfp_pkg::PH_DONE : csfp_pkg::PH_SPACE;
    return 1'b1;
  endfunction

  // Advances the parser by one file word; returns 1 when that word completes a result.
  function automatic bit next_swatch(input logic [15:0] w, input logic fend,
                                     output swatch_t res);
    res = '0;
    if (ph >= csfp_pkg::PH_DONE) return 1'b0;
    if (fend) begin
      res.status = (ph == csfp_pkg::PH_VERSION) ? csfp_pkg::ST_BAD_VERSION
                                                : csfp_pkg::ST_TRUNCATED;
      res.entry_index = (ph == csfp_pkg::PH_VERSION) ? 16'd0 : n_done;
      ph = csfp_pkg::PH_DONE;
      return 1'b1;
    end
    case (ph)
      csfp_pkg::PH_VERSION: begin
        if (w != csfp_pkg::VERSION_ONE && w != csfp_pkg::VERSION_TWO) begin
          res.status = csfp_pkg::ST_BAD_VERSION;
          ph = csfp_pkg::PH_DONE;
          return 1'b1;
        end
        is_v2 = (w == csfp_pkg::VERSION_TWO);
        ph = csfp_pkg::PH_COUNT;
      end
      csfp_pkg::PH_COUNT: begin
        n_total = w;
        n_done = '0;
        ph = (w == 16'd0) ? csfp_pkg::PH_DONE : csfp_pkg::PH_SPACE;
      end
      csfp_pkg::PH_SPACE: begin
        is_rgb = (w == 16'd0);
        red_q = '0;
        green_q = '0;
        blue_q = '0;
        ph = csfp_pkg::PH_COMP1;
      end
      csfp_pkg::PH_COMP1: begin
        if (is_rgb) red_q = w[15:8];
        ph = csfp_pkg::PH_COMP2;
      end
      csfp_pkg::PH_COMP2: begin
        if (is_rgb) green_q = w[15:8];
        ph = csfp_pkg::PH_COMP3;
      end
      csfp_pkg::PH_COMP3: begin
        if (is_rgb) blue_q = w[15:8];
        ph = csfp_pkg::PH_COMP4;
      end
      csfp_pkg::PH_COMP4: begin
        if (!is_v2) return close_entry(res);
        ph = csfp_pkg::PH_ZERO;
      end
      csfp_pkg::PH_ZERO: ph = csfp_pkg::PH_NAMELEN;
      csfp_pkg::PH_NAMELEN: begin
        if (w == 16'd0) return close_entry(res);
        name_left = w;
        ph = csfp_pkg::PH_NAME;
      end
      default: begin
        name_left = 16'(name_left - 16'd1);
        if (name_left == 16'd0) return close_entry(res);
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_word(input logic [15:0] w);
    file_word_t item;
    item.word = w;
    item.fend = 1'b0;
    body_words.push_back(item);
  endtask

  // A version 1 entry ends after the fourth component; version 2 adds the zero word,
  // the name length and the name.
  task automatic add_entry(input logic [15:0] space, input logic [15:0] c1,
                           input logic [15:0] c2, input logic [15:0] c3,
                           input logic [15:0] c4, input logic [15:0] zero_w,
                           input int name_len);
    add_word(space);
    add_word(c1);
    add_word(c2);
    add_word(c3);
    add_word(c4);
    if (file_version == csfp_pkg::VERSION_TWO) begin
      add_word(zero_w);
      add_word(16'(name_len));
      for (int i = 0; i < name_len; i++) add_word(16'($urandom));
    end
  endtask

  task automatic add_random_entry();
    logic [15:0] space;
    int r;
    int name_len;
    space = ($urandom_range(0, 9) < 7) ? 16'd0 : 16'($urandom_range(1, 65535));
    r = $urandom_range(0, 99);
    if (r < 50) name_len = $urandom_range(0, 3);
    else if (r < 95) name_len = $urandom_range(4, 12);
    else name_len = $urandom_range(20, 60);
    add_entry(space, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd0, name_len);
  endtask

  task automatic note_mismatch(input string what, input swatch_t want, input swatch_t got);
    if (mismatches < 10) begin
      $display("%s: expected r=%h g=%h b=%h idx=%0d st=%0d last=%b", what, want.red,
               want.green, want.blue, want.entry_index, want.status, want.last_entry);
      $display("%s: actual   r=%h g=%h b=%h idx=%0d st=%0d last=%b", what, got.red,
               got.green, got.blue, got.entry_index, got.status, got.last_entry);
    end
    mismatches++;
  endtask

  // Result check runs before prediction: a word accepted at this edge cannot have
  // produced a result at the same edge.
  always @(posedge clk) begin
    swatch_t want;
    swatch_t got;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.red = out_tdata[7:0];
      got.green = out_tdata[15:8];
      got.blue = out_tdata[23:16];
      got.entry_index = out_tdata[39:24];
      got.status = out_tuser;
      got.last_entry = out_tlast;
      if (pending_swatches.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_swatches.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
      results_seen++;
      if (got.status == csfp_pkg::ST_RGB) rgb_seen++;
      else if (got.status == csfp_pkg::ST_SKIPPED) skipped_seen++;
      else errors_seen++;
    end
    if (rst_n && in_tvalid && in_tready) begin
      words_sent++;
      if (next_swatch(in_tdata, in_tlast, want)) pending_swatches.push_back(want);
    end
  end

  always @(negedge clk) begin
    file_word_t nxt;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (in_pause > 0) begin
        in_pause--;
        in_tvalid <= 1'b0;
      end else if (file_words.size() > 0) begin
        nxt = file_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nxt.word;
        in_tlast <= nxt.fend;
        if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
        in_pause = in_steady ? 0 : pick_pause();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: short random stalls, and once a long one so the input side backs up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && results_seen >= 30) begin
        out_pause = LongHold;
        long_hold_done = 1'b1;
      end else if (out_pause == 0) begin
        if ($urandom_range(0, 49) == 0) out_steady = !out_steady;
        out_pause = out_steady ? 0 : pick_pause();
      end
      if (out_pause > 0) begin
        out_pause--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[color_swatch_file_parser] ERROR");
      $finish;
    end
  end

  initial begin
    file_word_t item;
    int keep;
    file_version = ($urandom_range(0, 3) == 0) ? csfp_pkg::VERSION_ONE
                                                : csfp_pkg::VERSION_TWO;
    // Directed entries: component extremes, a zero and a one-word name, non-rgb spaces.
    add_entry(16'd0, 16'hFFFF, 16'h0000, 16'h80FF, 16'hFFFF, 16'h0000, 0);
    add_entry(16'd0, 16'h00FF, 16'hFF00, 16'h7F00, 16'h0000, 16'hFFFF, 1);
    add_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 2);
    add_entry(16'd1, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0001, 16'h0000, 0);
    entries_full = 4;
    while (body_words.size() < BodyWords) begin
      add_random_entry();
      entries_full++;
    end
    file_cut = 1'($urandom_range(0, 1));
    if (file_cut) begin
      // Keep only a prefix of one more entry, then end the file inside it.
      keep = body_words.size();
      add_random_entry();
      keep = keep + $urandom_range(0, body_words.size() - keep - 1);
      while (body_words.size() > keep) void'(body_words.pop_back());
      item.word = 16'($urandom);
      item.fend = 1'b1;
      body_words.push_back(item);
      file_count = 16'($urandom_range(entries_full + 1, 65535));
    end else begin
      file_count = 16'(entries_full);
    end
    item.fend = 1'b0;
    item.word = file_version;
    file_words.push_back(item);
    item.word = file_count;
    file_words.push_back(item);
    foreach (body_words[i]) file_words.push_back(body_words[i]);
    // Words after the end of parsing must be ignored.
    for (int i = 0; i < 8; i++) begin
      item.word = 16'($urandom);
      item.fend = (i == 3) ? 1'b1 : 1'($urandom_range(0, 1));
      file_words.push_back(item);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (file_words.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_swatches.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Version %0d file, %0d entries announced, %0d words sent, %s.",
             file_version, file_count, words_sent,
             file_cut ? "cut short by end of file" : "all entries present");
    $display("Results: %0d color, %0d skipped, %0d error; %0d mismatches.",
             rgb_seen, skipped_seen, errors_seen, mismatches);
    if (mismatches == 0) begin
      $display("[color_swatch_file_parser] OK");
    end else begin
      $display("[color_swatch_file_parser] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/csfp_pkg.sv
rtl/core/csfp_parse.sv
rtl/core/color_swatch_file_parser.sv
test/tb_top.sv
